### hdl/page_quota_container_table_unit_assert.svh
// Assertion macros for the page quota container table.
// Included by the top level; compiles to nothing when SYNTHESIS is defined.
`ifndef PAGE_QUOTA_CONTAINER_TABLE_UNIT_ASSERT_SVH
`define PAGE_QUOTA_CONTAINER_TABLE_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define PQCT_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pqct assertion failed");

// next-cycle implication
`define PQCT_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pqct assertion failed");

`else

`define PQCT_ASSERT_IMP(label, clk, rst, ante, cons)
`define PQCT_ASSERT_NXT(label, clk, rst, ante, cons)

`endif

`endif

### hdl/pqct_pkg.sv
// Shared types and constants for the page quota container table.
// No dependencies; used by the interfaces, controller, datapath and top level.
`default_nettype none

package pqct_pkg;

  // field widths fixed by the request and result formats
  localparam int OP_W       = 3;
  localparam int ID_W       = 6;
  localparam int AMT_W      = 20;
  localparam int CHILD_ID_W = 7;
  localparam int QOUT_W     = 20;
  localparam int PAR_W      = 6;
  localparam int KIDS_OUT_W = 2;
  localparam int ROOTQ_W    = 20;

  // default sizing
  localparam int NUM_CONTAINERS_DEF = 64;
  localparam int MAX_KIDS_DEF       = 3;
  localparam int COUNT_BITS_DEF     = 20;

  // operation codes
  typedef enum logic [OP_W-1:0] {
    OP_INIT  = 3'd0,
    OP_SPLIT = 3'd1,
    OP_ALLOC = 3'd2,
    OP_FREE  = 3'd3,
    OP_QUERY = 3'd4
  } op_t;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_CHILD
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic accept;      // request taken, start table read
    logic exec_fire;   // apply operation, load result register
    logic child_fire;  // write new child entry
  } ctl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_free;    // result register can take a new result
    logic split_ok;    // current request is a split that succeeds
  } dp_stat_t;

endpackage

`default_nettype wire

### hdl/pqct_req_if.sv
// Request channel: valid/ready handshake carrying one table operation.
// Depends on pqct_pkg for field widths.
`default_nettype none

interface pqct_req_if import pqct_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic [ID_W-1:0]   container_id;
  logic [AMT_W-1:0]  amount;

  modport source (output valid, operation, container_id, amount, input ready);
  modport sink   (input valid, operation, container_id, amount, output ready);
endinterface

`default_nettype wire

### hdl/pqct_rsp_if.sv
// Result channel: valid/ready handshake carrying one operation result.
// Depends on pqct_pkg for field widths.
`default_nettype none

interface pqct_rsp_if import pqct_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic                  ok;
  logic [CHILD_ID_W-1:0] child_id;
  logic [QOUT_W-1:0]     quota_out;
  logic [QOUT_W-1:0]     usage_out;
  logic [PAR_W-1:0]      parent_out;
  logic [KIDS_OUT_W-1:0] child_count_out;
  logic                  in_use_out;

  modport source (output valid, ok, child_id, quota_out, usage_out, parent_out,
                  child_count_out, in_use_out, input ready);
  modport sink   (input valid, ok, child_id, quota_out, usage_out, parent_out,
                  child_count_out, in_use_out, output ready);
endinterface

`default_nettype wire

### hdl/pqct_ctrl.sv
// Controller state machine: sequences table read, update and child write.
// Depends on pqct_pkg for state, command and status types.
`default_nettype none

module pqct_ctrl import pqct_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     req_valid,
  output logic          req_ready,
  input  wire dp_stat_t stat,
  output ctl_cmd_t      cmd
);

  state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req_valid) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        if (stat.out_free) state_next = stat.split_ok ? ST_CHILD : ST_IDLE;
      end
      ST_CHILD: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    req_ready      = 1'b0;
    cmd.accept     = 1'b0;
    cmd.exec_fire  = 1'b0;
    cmd.child_fire = 1'b0;
    case (state)
      ST_IDLE: begin
        req_ready  = 1'b1;
        cmd.accept = req_valid;
      end
      ST_EXEC: begin
        cmd.exec_fire = stat.out_free;
      end
      ST_CHILD: begin
        cmd.child_fire = 1'b1;
      end
      default: begin
        req_ready = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

### hdl/pqct_dp.sv
// Datapath: container table memory, valid bits, operation logic, result register.
// Depends on pqct_pkg; driven by pqct_ctrl through ctl_cmd_t.
`default_nettype none

module pqct_dp import pqct_pkg::*; #(
  parameter int NUM_CONTAINERS = NUM_CONTAINERS_DEF,
  parameter int MAX_KIDS       = MAX_KIDS_DEF,
  parameter int COUNT_BITS     = COUNT_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire ctl_cmd_t              cmd,
  output dp_stat_t                   stat,
  input  wire logic                  cfg_we,
  input  wire logic [ROOTQ_W-1:0]    cfg_wdata,
  input  wire logic [OP_W-1:0]       operation,
  input  wire logic [ID_W-1:0]       container_id,
  input  wire logic [AMT_W-1:0]      amount,
  input  wire logic                  rsp_ready,
  output logic                       rsp_valid,
  output logic                       ok,
  output logic [CHILD_ID_W-1:0]      child_id,
  output logic [QOUT_W-1:0]          quota_out,
  output logic [QOUT_W-1:0]          usage_out,
  output logic [PAR_W-1:0]           parent_out,
  output logic [KIDS_OUT_W-1:0]      child_count_out,
  output logic                       in_use_out
);

  localparam int AW  = (NUM_CONTAINERS > 1) ? $clog2(NUM_CONTAINERS) : 1;
  localparam int CB  = COUNT_BITS;
  localparam int KW  = $clog2(MAX_KIDS + 1);
  localparam int CHW = $clog2((2 ** ID_W) * (MAX_KIDS + 1) + 1);

  typedef struct packed {
    logic [CB-1:0]    quota;
    logic [CB-1:0]    usage;
    logic [PAR_W-1:0] parent;
    logic [KW-1:0]    kids;
    logic             in_use;
  } entry_t;

  // configuration
  logic [ROOTQ_W-1:0] root_quota;

  always_ff @(posedge clk) begin
    if (rst) begin
      root_quota <= '0;
    end else if (cfg_we) begin
      root_quota <= cfg_wdata;
    end
  end

  // latched request
  logic [OP_W-1:0] op_q;
  logic [ID_W-1:0] id_q;
  logic [CB-1:0]   amt_q;
  logic [AW-1:0]   child_q;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_q  <= operation;
      id_q  <= container_id;
      amt_q <= CB'(amount);
    end
  end

  // table memory with registered read; valid bits stand in for the zero reset
  entry_t                    mem [NUM_CONTAINERS];
  logic [NUM_CONTAINERS-1:0] vld;
  logic [AW-1:0]             rd_addr;
  entry_t                    rd_q;
  logic                      rd_vld_q;
  logic                      wr_en;
  logic [AW-1:0]             wr_addr;
  entry_t                    wr_data;

  assign rd_addr = (operation == OP_INIT) ? '0 : AW'(container_id);

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      rd_q <= mem[rd_addr];
    end
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld      <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (cmd.accept) rd_vld_q <= vld[rd_addr];
      if (wr_en)      vld[wr_addr] <= 1'b1;
    end
  end

  // operation logic
  entry_t               ent;
  entry_t               ent_new;
  entry_t               child_ent;
  logic                 id_ok;
  logic                 upd;
  logic                 res_ok;
  logic                 split_ok;
  logic [CHW-1:0]       child;
  logic [CB:0]          sum;
  logic [CB-1:0]        headroom;
  logic [AW-1:0]        ex_addr;

  assign ent      = rd_vld_q ? rd_q : '0;
  assign id_ok    = 32'(id_q) < NUM_CONTAINERS;
  assign child    = CHW'(id_q) * CHW'(MAX_KIDS) + CHW'(ent.kids) + CHW'(1);
  assign sum      = {1'b0, ent.usage} + {1'b0, amt_q};
  assign headroom = ent.quota - ent.usage;
  assign ex_addr  = (op_q == OP_INIT) ? '0 : AW'(id_q);

  always_comb begin
    ent_new  = ent;
    upd      = 1'b0;
    res_ok   = 1'b0;
    split_ok = 1'b0;
    if (op_q == OP_INIT) begin
      ent_new.quota  = CB'(root_quota);
      ent_new.usage  = '0;
      ent_new.parent = '0;
      ent_new.kids   = '0;
      ent_new.in_use = 1'b1;
      upd            = 1'b1;
      res_ok         = 1'b1;
    end else if (id_ok) begin
      case (op_q)
        OP_SPLIT: begin
          if ((32'(ent.kids) < MAX_KIDS) && (32'(child) < NUM_CONTAINERS)) begin
            ent_new.usage = sum[CB] ? '1 : sum[CB-1:0];
            ent_new.kids  = ent.kids + KW'(1);
            upd           = 1'b1;
            res_ok        = 1'b1;
            split_ok      = 1'b1;
          end
        end
        OP_ALLOC: begin
          if (ent.in_use && (ent.usage < ent.quota)) begin
            ent_new.usage = ent.usage + CB'(1);
            upd           = 1'b1;
            res_ok        = 1'b1;
          end
        end
        OP_FREE: begin
          if (ent.in_use && (ent.usage != '0)) begin
            ent_new.usage = ent.usage - CB'(1);
            upd           = 1'b1;
            res_ok        = 1'b1;
          end
        end
        OP_QUERY: begin
          res_ok = (ent.usage <= ent.quota) && (headroom >= amt_q);
        end
        default: begin
          res_ok = 1'b0;
        end
      endcase
    end
  end

  // new child entry
  always_comb begin
    child_ent.quota  = amt_q;
    child_ent.usage  = '0;
    child_ent.parent = id_q;
    child_ent.kids   = '0;
    child_ent.in_use = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (cmd.exec_fire) begin
      child_q <= AW'(child);
    end
  end

  // single write port: addressed entry on exec, child entry in the following cycle
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = ex_addr;
    wr_data = ent_new;
    if (cmd.child_fire) begin
      wr_en   = 1'b1;
      wr_addr = child_q;
      wr_data = child_ent;
    end else if (cmd.exec_fire && upd) begin
      wr_en = 1'b1;
    end
  end

  // status
  assign stat.out_free = !rsp_valid || rsp_ready;
  assign stat.split_ok = split_ok;

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.exec_fire) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec_fire) begin
      ok       <= res_ok;
      child_id <= split_ok ? CHILD_ID_W'(child) : CHILD_ID_W'(NUM_CONTAINERS);
      if ((op_q == OP_INIT) || id_ok) begin
        quota_out       <= QOUT_W'(ent_new.quota);
        usage_out       <= QOUT_W'(ent_new.usage);
        parent_out      <= ent_new.parent;
        child_count_out <= KIDS_OUT_W'(ent_new.kids);
        in_use_out      <= ent_new.in_use;
      end else begin
        quota_out       <= '0;
        usage_out       <= '0;
        parent_out      <= '0;
        child_count_out <= '0;
        in_use_out      <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

### hdl/page_quota_container_table_unit.sv
// Page quota container table: a table of containers, each with a page quota,
// usage, parent, child count and in-use flag, serving init, split, alloc, free
// and query requests one at a time. A request takes a table read, then update
// and result, and a successful split also a second write to the single-port
// table for the new child entry. The result register lets the next request
// enter while a result waits to be taken; a new result is loaded only once
// the previous one has left. The table is a memory with registered read; one
// valid bit per entry, cleared by reset, makes never-written entries read as
// zero, so no clearing pass is needed.
`default_nettype none
`include "page_quota_container_table_unit_assert.svh"

module page_quota_container_table_unit import pqct_pkg::*; #(
  parameter int NUM_CONTAINERS = NUM_CONTAINERS_DEF,
  parameter int MAX_KIDS       = MAX_KIDS_DEF,
  parameter int COUNT_BITS     = COUNT_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  pqct_req_if.sink                req,
  pqct_rsp_if.source              rsp,
  input  wire logic               cfg_we,
  input  wire logic [ROOTQ_W-1:0] cfg_wdata
);

  ctl_cmd_t cmd;
  dp_stat_t stat;
  logic     req_ready;

  assign req.ready = req_ready;

  // controller
  pqct_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // datapath
  pqct_dp #(
    .NUM_CONTAINERS (NUM_CONTAINERS),
    .MAX_KIDS       (MAX_KIDS),
    .COUNT_BITS     (COUNT_BITS)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .stat            (stat),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .operation       (req.operation),
    .container_id    (req.container_id),
    .amount          (req.amount),
    .rsp_ready       (rsp.ready),
    .rsp_valid       (rsp.valid),
    .ok              (rsp.ok),
    .child_id        (rsp.child_id),
    .quota_out       (rsp.quota_out),
    .usage_out       (rsp.usage_out),
    .parent_out      (rsp.parent_out),
    .child_count_out (rsp.child_count_out),
    .in_use_out      (rsp.in_use_out)
  );

  // one request in flight: no accept in the cycle after an accept
  `PQCT_ASSERT_NXT(a_one_in_flight, clk, rst, req.valid && req_ready, !req_ready)
  // child entry write only follows a successful split
  `PQCT_ASSERT_IMP(a_child_after_split, clk, rst, cmd.child_fire, $past(cmd.exec_fire && stat.split_ok))
  // a result appears only after an operation was applied
  `PQCT_ASSERT_IMP(a_rsp_from_exec, clk, rst, $rose(rsp.valid), $past(cmd.exec_fire))

endmodule

`default_nettype wire

### tb/sv/page_quota_container_table_unit_tb.sv
// Self-checking testbench for page_quota_container_table_unit: directed and random requests,
// each result checked against an in-bench model of the container table.
// Depends on pqct_pkg, pqct_req_if, pqct_rsp_if and the unit itself.
`default_nettype none

module page_quota_container_table_unit_tb import pqct_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NUM_C = NUM_CONTAINERS_DEF;
  localparam int unsigned KIDS_MAX = MAX_KIDS_DEF;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam logic [COUNT_BITS_DEF-1:0] COUNT_MAX = '1;
  localparam logic [AMT_W-1:0] AMT_MAX = '1;
  // codes with no operation behind them
  localparam logic [OP_W-1:0] OP_UNUSED_FIRST = OP_QUERY + 1'b1;
  localparam logic [OP_W-1:0] OP_UNUSED_LAST = '1;

  typedef struct packed {
    logic                  ok;
    logic [CHILD_ID_W-1:0] child_id;
    logic [QOUT_W-1:0]     quota;
    logic [QOUT_W-1:0]     usage;
    logic [PAR_W-1:0]      parent;
    logic [KIDS_OUT_W-1:0] kids;
    logic                  in_use;
  } table_result_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [ROOTQ_W-1:0] cfg_wdata;

  pqct_req_if req_ch ();
  pqct_rsp_if rsp_ch ();

  page_quota_container_table_unit dut (
    .clk       (clk),
    .rst       (rst),
    .req       (req_ch),
    .rsp       (rsp_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // model of the container table
  logic [ROOTQ_W-1:0]        root_quota_m;
  logic [COUNT_BITS_DEF-1:0] quota_tbl  [NUM_C];
  logic [COUNT_BITS_DEF-1:0] usage_tbl  [NUM_C];
  logic [PAR_W-1:0]          parent_tbl [NUM_C];
  logic [KIDS_OUT_W-1:0]     kids_tbl   [NUM_C];
  logic                      live_tbl   [NUM_C];

  table_result_t pending_results [$];
  int unsigned   err_count = 0;
  int unsigned   cycle_count = 0;
  bit            no_throttle = 1'b0;
  int unsigned   ready_hold = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // apply one request to the model, return the result it must produce
  function automatic table_result_t apply_table_op(logic [OP_W-1:0] op, logic [ID_W-1:0] id,
                                                   logic [AMT_W-1:0] amt);
    table_result_t r;
    int unsigned at, nc, child;
    logic [COUNT_BITS_DEF:0] sum;
    r = '0;
    r.child_id = CHILD_ID_W'(NUM_C);
    at = id;
    case (op)
      OP_INIT: begin
        at = 0;
        quota_tbl[0] = root_quota_m;
        usage_tbl[0] = '0;
        parent_tbl[0] = '0;
        kids_tbl[0] = '0;
        live_tbl[0] = 1'b1;
        r.ok = 1'b1;
      end
      OP_SPLIT: begin
        nc = kids_tbl[id];
        child = id * KIDS_MAX + 1 + nc;
        if (nc < KIDS_MAX && child < NUM_C) begin
          // parent usage saturates
          sum = {1'b0, usage_tbl[id]} + amt;
          usage_tbl[id] = (sum > COUNT_MAX) ? COUNT_MAX : sum[COUNT_BITS_DEF-1:0];
          kids_tbl[id] = KIDS_OUT_W'(nc + 1);
          quota_tbl[child] = amt;
          usage_tbl[child] = '0;
          parent_tbl[child] = id;
          kids_tbl[child] = '0;
          live_tbl[child] = 1'b1;
          r.child_id = CHILD_ID_W'(child);
          r.ok = 1'b1;
        end
      end
      OP_ALLOC: begin
        if (live_tbl[id] && usage_tbl[id] < quota_tbl[id]) begin
          usage_tbl[id] = usage_tbl[id] + 1'b1;
          r.ok = 1'b1;
        end
      end
      OP_FREE: begin
        if (live_tbl[id] && usage_tbl[id] != '0) begin
          usage_tbl[id] = usage_tbl[id] - 1'b1;
          r.ok = 1'b1;
        end
      end
      OP_QUERY: begin
        r.ok = (usage_tbl[id] <= quota_tbl[id]) && (quota_tbl[id] - usage_tbl[id] >= amt);
      end
      default: ;
    endcase
    r.quota = quota_tbl[at];
    r.usage = usage_tbl[at];
    r.parent = parent_tbl[at];
    r.kids = kids_tbl[at];
    r.in_use = live_tbl[at];
    return r;
  endfunction

  // idle length: mostly none or short, now and then long
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (no_throttle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  // container that is in use, when there is one
  function automatic logic [ID_W-1:0] pick_live_id();
    int unsigned live_ids [$];
    for (int unsigned c = 0; c < NUM_C; c++)
      if (live_tbl[c]) live_ids.push_back(c);
    if (live_ids.size() == 0) return ID_W'($urandom_range(0, NUM_C - 1));
    return ID_W'(live_ids[$urandom_range(0, live_ids.size() - 1)]);
  endfunction

  // send one request; valid is left as is so a back-to-back request follows
  task automatic send_request(logic [OP_W-1:0] op, logic [ID_W-1:0] id, logic [AMT_W-1:0] amt);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.operation <= op;
    req_ch.container_id <= id;
    req_ch.amount <= amt;
    do @(posedge clk); while (!req_ch.ready);
    pending_results.push_back(apply_table_op(op, id, amt));
  endtask

  // stop requesting and wait for every outstanding result
  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic set_root_quota(logic [ROOTQ_W-1:0] value);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    root_quota_m = value;
    cfg_we <= 1'b0;
  endtask

  // behavior straight out of reset, root quota still zero
  task automatic test_reset_values();
    send_request(OP_QUERY, 6'd63, '0);
    send_request(OP_ALLOC, 6'd5, '0);
    send_request(OP_FREE, 6'd0, '0);
    send_request(OP_INIT, 6'd0, '0);
    send_request(OP_ALLOC, 6'd0, '0);
    wait_drained();
  endtask

  // build a small tree and walk the refusal and saturation cases
  task automatic test_directed_tree();
    int k;
    set_root_quota('1);
    send_request(OP_INIT, 6'd63, AMT_MAX);        // id and amount ignored
    send_request(OP_SPLIT, 6'd0, AMT_MAX);
    send_request(OP_SPLIT, 6'd0, AMT_MAX);        // parent usage saturates
    send_request(OP_SPLIT, 6'd0, 20'd1);
    send_request(OP_SPLIT, 6'd0, 20'd7);          // child count full
    send_request(OP_ALLOC, 6'd0, '0);             // usage at quota
    send_request(OP_QUERY, 6'd0, '0);
    send_request(OP_FREE, 6'd0, '0);
    send_request(OP_ALLOC, 6'd0, '0);
    send_request(OP_SPLIT, 6'd3, 20'd5);          // usage now above quota
    send_request(OP_QUERY, 6'd3, '0);
    send_request(OP_ALLOC, 6'd3, '0);
    send_request(OP_FREE, 6'd10, '0);             // usage zero
    send_request(OP_ALLOC, 6'd10, '0);
    send_request(OP_QUERY, 6'd10, 20'd4);
    send_request(OP_QUERY, 6'd10, 20'd5);
    send_request(OP_SPLIT, 6'd21, 20'd2);         // child index past the table
    send_request(OP_SPLIT, 6'd20, 20'd3);
    send_request(OP_SPLIT, 6'd63, AMT_MAX);
    for (k = OP_UNUSED_FIRST; k <= OP_UNUSED_LAST; k++)
      send_request(OP_W'(k), 6'd10, AMT_MAX);
    wait_drained();
  endtask

  // one root quota setting, then mostly well-formed random traffic
  task automatic test_random_phase(logic [ROOTQ_W-1:0] rq, bit quiet, int unsigned count);
    logic [OP_W-1:0]  op;
    logic [ID_W-1:0]  id;
    logic [AMT_W-1:0] amt;
    int unsigned      r;
    set_root_quota(rq);
    no_throttle = quiet;
    send_request(OP_INIT, ID_W'($urandom), AMT_W'($urandom));
    for (int unsigned i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < 4) op = OP_INIT;
      else if (r < 24) op = OP_SPLIT;
      else if (r < 52) op = OP_ALLOC;
      else if (r < 72) op = OP_FREE;
      else if (r < 94) op = OP_QUERY;
      else op = OP_W'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST));
      if ($urandom_range(0, 99) < 75) id = pick_live_id();
      else id = ID_W'($urandom_range(0, NUM_C - 1));
      r = $urandom_range(0, 99);
      if (r < 60) amt = AMT_W'($urandom_range(0, 24));
      else if (r < 80) amt = quota_tbl[id] - usage_tbl[id] + AMT_W'($urandom_range(0, 2)) - 1'b1;
      else if (r < 92) amt = AMT_W'($urandom);
      else amt = AMT_MAX;
      send_request(op, id, amt);
    end
    wait_drained();
    no_throttle = 1'b0;
  endtask

  // result ready with random stalls
  always @(posedge clk) begin : rsp_throttle
    int unsigned len;
    if (no_throttle) begin
      rsp_ch.ready <= 1'b1;
    end else if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
    end else if (rsp_ch.ready) begin
      len = pick_gap();
      if (len != 0) begin
        rsp_ch.ready <= 1'b0;
        ready_hold <= len - 1;
      end else begin
        ready_hold <= $urandom_range(0, 6);
      end
    end else begin
      rsp_ch.ready <= 1'b1;
      ready_hold <= $urandom_range(0, 6);
    end
  end

  // compare each taken result with the oldest prediction
  always @(posedge clk) begin : result_check
    table_result_t want, got;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      got.ok = rsp_ch.ok;
      got.child_id = rsp_ch.child_id;
      got.quota = rsp_ch.quota_out;
      got.usage = rsp_ch.usage_out;
      got.parent = rsp_ch.parent_out;
      got.kids = rsp_ch.child_count_out;
      got.in_use = rsp_ch.in_use_out;
      if (pending_results.size() == 0) begin
        err_count++;
        if (err_count <= 10)
          $display("unexpected result: ok=%0d child=%0d quota=%h usage=%h", got.ok,
                   got.child_id, got.quota, got.usage);
      end else begin
        want = pending_results.pop_front();
        if (want !== got) begin
          err_count++;
          if (err_count <= 10)
            $display("mismatch: expected ok=%0d child=%0d quota=%h usage=%h par=%0d kids=%0d use=%0d, got ok=%0d child=%0d quota=%h usage=%h par=%0d kids=%0d use=%0d",
                     want.ok, want.child_id, want.quota, want.usage, want.parent,
                     want.kids, want.in_use, got.ok, got.child_id, got.quota,
                     got.usage, got.parent, got.kids, got.in_use);
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL page_quota_container_table_unit");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    req_ch.valid = 1'b0;
    req_ch.operation = '0;
    req_ch.container_id = '0;
    req_ch.amount = '0;
    rsp_ch.ready = 1'b0;
    root_quota_m = '0;
    for (int unsigned c = 0; c < NUM_C; c++) begin
      quota_tbl[c] = '0;
      usage_tbl[c] = '0;
      parent_tbl[c] = '0;
      kids_tbl[c] = '0;
      live_tbl[c] = 1'b0;
    end
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    test_reset_values();
    test_directed_tree();
    test_random_phase('1, 1'b0, 200);
    test_random_phase('0, 1'b0, 120);
    test_random_phase(ROOTQ_W'($urandom_range(1, 16)), 1'b1, 200);
    test_random_phase(ROOTQ_W'($urandom), 1'b0, 200);
    test_random_phase(ROOTQ_W'($urandom_range(1, 64)), 1'b0, 150);

    wait_drained();
    repeat (16) @(posedge clk);
    if (err_count == 0) begin
      $display("PASS page_quota_container_table_unit");
    end else begin
      $display("FAIL page_quota_container_table_unit");
    end
    $finish;
  end

endmodule

`default_nettype wire

### files.f
+incdir+hdl
hdl/pqct_pkg.sv
hdl/pqct_req_if.sv
hdl/pqct_rsp_if.sv
hdl/pqct_ctrl.sv
hdl/pqct_dp.sv
hdl/page_quota_container_table_unit.sv
tb/sv/page_quota_container_table_unit_tb.sv
